// ----- rtl/core/vsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_pkg : shared constants for the vector similarity metric block
// widths of the element, running sums, root and divider datapaths
// ----------------------------------------------------------------------------
package vsm_pkg;

    localparam int ELEM_WIDTH = 16;     // element bits taken from each field
    localparam int MUL_W      = 23;     // signed operand width of shared multiplier
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DOT_W      = 44;
    localparam int NORM_W     = 43;
    localparam int DIFF_W     = 45;
    localparam int SQ_IN_W    = 48;     // radicand width of the root unit
    localparam int SQ_ROOT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W   = SQ_ROOT_W + 2;
    localparam int ROOT_W     = 22;     // root of a norm sum
    localparam int DEN_W      = 2 * ROOT_W;
    localparam int NUM_W      = 59;     // |dot| * 2^15 plus half the denominator
    localparam int QUO_W      = 17;
    localparam int COS_W      = 16;
    localparam int DIST_W     = 24;

endpackage

// ----- rtl/core/vsm_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_mul : shared signed multiplier
// one registered signed product per cycle, used for all element products
// and for the denominator of the cosine
// ----------------------------------------------------------------------------
module vsm_mul (
    input  logic                                 i_clk,
    input  logic signed [vsm_pkg::MUL_W-1:0]     i_op_a,
    input  logic signed [vsm_pkg::MUL_W-1:0]     i_op_b,
    output logic signed [vsm_pkg::PROD_W-1:0]    o_prod
);

    logic signed [vsm_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/vsm_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_sqrt : iterative integer square root
// two radicand bits per cycle, gives floor root and remainder
// ----------------------------------------------------------------------------
module vsm_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vsm_pkg::SQ_IN_W-1:0]       i_x,
    output logic                              o_done,
    output logic [vsm_pkg::SQ_ROOT_W-1:0]     o_root,
    output logic [vsm_pkg::SQ_REM_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(vsm_pkg::SQ_ROOT_W);

    logic [vsm_pkg::SQ_IN_W-1:0]   r_x;
    logic [vsm_pkg::SQ_REM_W-1:0]  r_rem;
    logic [vsm_pkg::SQ_ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [vsm_pkg::SQ_REM_W-1:0]  rem_sh;
    logic [vsm_pkg::SQ_REM_W-1:0]  trial;
    logic                          take;

    assign rem_sh = {r_rem[vsm_pkg::SQ_REM_W-3:0], r_x[vsm_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(vsm_pkg::SQ_ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[vsm_pkg::SQ_IN_W-3:0], 2'b00};
            r_cnt <= r_cnt + CNT_W'(1);
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[vsm_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[vsm_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/vsm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_div : iterative restoring divider
// one quotient bit per cycle; quotients past the 17-bit range flag overflow
// ----------------------------------------------------------------------------
module vsm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vsm_pkg::NUM_W-1:0]      i_num,
    input  logic [vsm_pkg::DEN_W-1:0]      i_den,
    output logic                           o_done,
    output logic [vsm_pkg::QUO_W-1:0]      o_quo,
    output logic                           o_ovf
);

    localparam int CNT_W = $clog2(vsm_pkg::QUO_W);
    localparam int SH_W  = vsm_pkg::DEN_W + vsm_pkg::QUO_W;

    logic [vsm_pkg::NUM_W-1:0] r_rem;
    logic [SH_W-1:0]           r_dsh;
    logic [vsm_pkg::QUO_W-1:0] r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_ovf;

    logic [SH_W-1:0]           full_den;
    logic                      ovf_now;
    logic                      take;

    assign full_den = {i_den, {vsm_pkg::QUO_W{1'b0}}};
    assign ovf_now  = full_den <= SH_W'(i_num);
    assign take     = SH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !ovf_now;
                r_done <= ovf_now;
            end else if (r_busy && r_cnt == CNT_W'(vsm_pkg::QUO_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {1'b0, i_den, {(vsm_pkg::QUO_W - 1){1'b0}}};
            r_quo <= '0;
            r_cnt <= '0;
            r_ovf <= ovf_now;
        end else if (r_busy) begin
            r_dsh <= {1'b0, r_dsh[SH_W-1:1]};
            r_cnt <= r_cnt + CNT_W'(1);
            r_quo <= {r_quo[vsm_pkg::QUO_W-2:0], take};
            if (take) begin
                r_rem <= r_rem - r_dsh[vsm_pkg::NUM_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

// ----- rtl/core/vector_similarity_metric_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_similarity_metric_top : cosine similarity / euclidean distance
// accumulates element pairs and gives one result per vector
// ----------------------------------------------------------------------------
// Each element pair runs through the transfer, three passes through the
// one shared 23x23 multiplier (a*b, a*a, b*b) and a final accumulate, with the
// squared difference formed as a*a + b*b - 2ab. A pair marked last adds the
// result phase: distance mode runs one square root, cosine mode runs two
// roots, one multiplier pass for the denominator and a divide; when a norm
// is zero the cosine result is degenerate and no root or divide runs.
// The result sits in an output register, so the next vector can start while it
// waits to be taken. metric_mode is sampled when the last pair finishes.
// ----------------------------------------------------------------------------
module vector_similarity_metric_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,     // metric_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // elem_a[15:0], elem_b[31:16]
    input  logic        i_s_axis_tlast,    // last_elem
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,    // cosine_q15[15:0], distance_q1[39:16]
    output logic        o_m_axis_tuser     // degenerate
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MAB  = 12'b0000_0000_0010,
        S_MAA  = 12'b0000_0000_0100,
        S_MBB  = 12'b0000_0000_1000,
        S_ACC  = 12'b0000_0001_0000,
        S_FIN  = 12'b0000_0010_0000,
        S_SQA  = 12'b0000_0100_0000,
        S_SQB  = 12'b0000_1000_0000,
        S_DEN  = 12'b0001_0000_0000,
        S_DENW = 12'b0010_0000_0000,
        S_DIV  = 12'b0100_0000_0000,
        S_DIST = 12'b1000_0000_0000
    } t_state;

    localparam int EW = vsm_pkg::ELEM_WIDTH;
    localparam int MW = vsm_pkg::MUL_W;

    t_state r_state, n_state;

    logic                                r_mode;
    logic signed [EW-1:0]                r_a, r_b;
    logic                                r_last;
    logic signed [vsm_pkg::DOT_W-1:0]    r_dot;
    logic [vsm_pkg::NORM_W-1:0]          r_norm_a, r_norm_b;
    logic [vsm_pkg::DIFF_W-1:0]          r_diff;
    logic signed [31:0]                  r_ab;
    logic [30:0]                         r_aa;
    logic [vsm_pkg::ROOT_W-1:0]          r_ra;

    logic                                r_res_pend;
    logic [vsm_pkg::COS_W-1:0]           r_res_cos;
    logic [vsm_pkg::DIST_W-1:0]          r_res_dist;
    logic                                r_res_degen;

    logic                                r_out_valid;
    logic [vsm_pkg::COS_W-1:0]           r_out_cos;
    logic [vsm_pkg::DIST_W-1:0]          r_out_dist;
    logic                                r_out_degen;

    logic signed [MW-1:0]                mul_a, mul_b;
    logic signed [vsm_pkg::PROD_W-1:0]   prod;

    logic                                sq_start, sq_done;
    logic [vsm_pkg::SQ_IN_W-1:0]         sq_x;
    logic [vsm_pkg::SQ_ROOT_W-1:0]       sq_root;
    logic [vsm_pkg::SQ_REM_W-1:0]        sq_rem;

    logic                                dv_start, dv_done, dv_ovf;
    logic [vsm_pkg::NUM_W-1:0]           dv_num;
    logic [vsm_pkg::DEN_W-1:0]           dv_den;
    logic [vsm_pkg::QUO_W-1:0]           dv_quo;

    logic                                in_xfer, out_free;
    logic signed [vsm_pkg::DOT_W:0]      dot_s;
    logic [vsm_pkg::NORM_W:0]            norm_s;
    logic [vsm_pkg::DIFF_W:0]            diff_s;
    logic signed [33:0]                  dsq;
    logic                                dot_neg;
    logic [vsm_pkg::DOT_W-1:0]           dot_mag;
    logic [vsm_pkg::SQ_ROOT_W:0]         dist_rnd;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_res_pend;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MAB: begin
                mul_a = MW'(r_a);
                mul_b = MW'(r_b);
            end
            S_MAA: begin
                mul_a = MW'(r_a);
                mul_b = MW'(r_a);
            end
            S_MBB: begin
                mul_a = MW'(r_b);
                mul_b = MW'(r_b);
            end
            S_DEN: begin
                mul_a = MW'({1'b0, r_ra});
                mul_b = MW'({1'b0, sq_root[vsm_pkg::ROOT_W-1:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vsm_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    vsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root),
        .o_rem   (sq_rem)
    );

    vsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf)
    );

    // saturating accumulation terms
    assign dot_s  = {r_dot[vsm_pkg::DOT_W-1], r_dot}
                  + (vsm_pkg::DOT_W + 1)'(signed'(prod[31:0]));
    assign norm_s = {1'b0, (r_state == S_MBB) ? r_norm_a : r_norm_b}
                  + (vsm_pkg::NORM_W + 1)'(prod[30:0]);
    // (a-b)^2 = a^2 + b^2 - 2ab, exact
    assign dsq    = 34'(signed'({1'b0, r_aa})) + 34'(signed'({1'b0, prod[30:0]}))
                  - 34'(signed'({r_ab, 1'b0}));
    assign diff_s = {1'b0, r_diff} + (vsm_pkg::DIFF_W + 1)'(dsq[32:0]);

    assign dot_neg = r_dot[vsm_pkg::DOT_W-1];
    assign dot_mag = dot_neg ? vsm_pkg::DOT_W'(-r_dot) : vsm_pkg::DOT_W'(r_dot);
    assign dist_rnd = {1'b0, sq_root}
                    + (vsm_pkg::SQ_ROOT_W + 1)'(sq_rem > {2'b00, sq_root});

    assign dv_den = prod[vsm_pkg::DEN_W-1:0];
    assign dv_num = {dot_mag, 15'b0} + vsm_pkg::NUM_W'(dv_den[vsm_pkg::DEN_W-1:1]);

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        sq_x     = '0;
        dv_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_MAB;
                end
            end
            S_MAB: n_state = S_MAA;
            S_MAA: n_state = S_MBB;
            S_MBB: n_state = S_ACC;
            S_ACC: n_state = r_last ? S_FIN : S_IDLE;
            S_FIN: begin
                if (r_mode) begin
                    sq_start = 1'b1;
                    sq_x     = {1'b0, r_diff, 2'b00};
                    n_state  = S_DIST;
                end else if (r_norm_a == '0 || r_norm_b == '0) begin
                    n_state = S_IDLE;
                end else begin
                    sq_start = 1'b1;
                    sq_x     = vsm_pkg::SQ_IN_W'(r_norm_a);
                    n_state  = S_SQA;
                end
            end
            S_SQA: begin
                if (sq_done) begin
                    sq_start = 1'b1;
                    sq_x     = vsm_pkg::SQ_IN_W'(r_norm_b);
                    n_state  = S_SQB;
                end
            end
            S_SQB: begin
                if (sq_done) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: n_state = S_DENW;
            S_DENW: begin
                dv_start = 1'b1;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (dv_done) begin
                    n_state = S_IDLE;
                end
            end
            S_DIST: begin
                if (sq_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_dot       <= '0;
            r_norm_a    <= '0;
            r_norm_b    <= '0;
            r_diff      <= '0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end

            case (r_state)
                S_MAA: begin
                    if (dot_s > (vsm_pkg::DOT_W + 1)'(signed'({2'b00, {(vsm_pkg::DOT_W - 1){1'b1}}}))) begin
                        r_dot <= {1'b0, {(vsm_pkg::DOT_W - 1){1'b1}}};
                    end else if (dot_s < (vsm_pkg::DOT_W + 1)'(signed'({2'b11, {(vsm_pkg::DOT_W - 1){1'b0}}}))) begin
                        r_dot <= {1'b1, {(vsm_pkg::DOT_W - 1){1'b0}}};
                    end else begin
                        r_dot <= dot_s[vsm_pkg::DOT_W-1:0];
                    end
                end
                S_MBB: begin
                    r_norm_a <= norm_s[vsm_pkg::NORM_W] ? '1 : norm_s[vsm_pkg::NORM_W-1:0];
                end
                S_ACC: begin
                    r_norm_b <= norm_s[vsm_pkg::NORM_W] ? '1 : norm_s[vsm_pkg::NORM_W-1:0];
                    r_diff   <= diff_s[vsm_pkg::DIFF_W] ? '1 : diff_s[vsm_pkg::DIFF_W-1:0];
                end
                default: ;
            endcase

            // result is staged and the sums are cleared for the next vector
            if ((r_state == S_FIN && !r_mode && (r_norm_a == '0 || r_norm_b == '0))
                || (r_state == S_DIV && dv_done) || (r_state == S_DIST && sq_done)) begin
                r_res_pend <= 1'b1;
                r_dot      <= '0;
                r_norm_a   <= '0;
                r_norm_b   <= '0;
                r_diff     <= '0;
            end else if (r_res_pend && out_free) begin
                r_res_pend <= 1'b0;
            end

            if (r_res_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a    <= i_s_axis_tdata[EW-1:0];
            r_b    <= i_s_axis_tdata[16+EW-1:16];
            r_last <= i_s_axis_tlast;
        end
        if (r_state == S_MAA) begin
            r_ab <= prod[31:0];
        end
        if (r_state == S_MBB) begin
            r_aa <= prod[30:0];
        end
        if (r_state == S_SQA && sq_done) begin
            r_ra <= sq_root[vsm_pkg::ROOT_W-1:0];
        end

        if (r_state == S_FIN) begin
            r_res_cos   <= '0;
            r_res_dist  <= '0;
            r_res_degen <= !r_mode;
        end
        if (r_state == S_DIST && sq_done) begin
            r_res_cos   <= '0;
            r_res_degen <= 1'b0;
            r_res_dist  <= dist_rnd[vsm_pkg::SQ_ROOT_W] ? '1 : dist_rnd[vsm_pkg::DIST_W-1:0];
        end
        if (r_state == S_DIV && dv_done) begin
            r_res_dist  <= '0;
            r_res_degen <= 1'b0;
            if (dot_neg) begin
                r_res_cos <= (dv_ovf || dv_quo > 17'd32768) ? 16'h8000 : 16'(-dv_quo);
            end else begin
                r_res_cos <= (dv_ovf || dv_quo > 17'd32767) ? 16'h7fff : dv_quo[15:0];
            end
        end

        if (r_res_pend && out_free) begin
            r_out_cos   <= r_res_cos;
            r_out_dist  <= r_res_dist;
            r_out_degen <= r_res_degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_dist, r_out_cos};
    assign o_m_axis_tuser  = r_out_degen;

    a_busy_after_xfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("input ready while an element is in work");

    a_sums_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_pend) |-> (r_norm_a == '0 && r_norm_b == '0 && r_diff == '0))
        else $error("running sums not cleared after a result");

    a_degen_no_dist : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result carries data");

    a_dist_no_cos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[39:16] != '0) |-> (o_m_axis_tdata[15:0] == '0))
        else $error("distance result with nonzero cosine");

endmodule

// ----- tb/vsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_checker : scoreboard for the vector similarity metric block
// follows config writes and input transfers, works out the expected
// cosine / distance for each last pair, and compares every output transfer
// ----------------------------------------------------------------------------
module vsm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [15:0] cosine;
        logic [23:0] distance;
        logic        degenerate;
    } t_metric;

    localparam longint DOT_LIM  = 64'sd8796093022207;     // 2^43 - 1
    localparam longint NORM_LIM = 64'sd8796093022207;
    localparam longint DIFF_LIM = 64'sd35184372088831;    // 2^45 - 1

    logic    mode;
    longint  dot_acc, norm_a_acc, norm_b_acc, diff_acc;
    t_metric expected_q[$];

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic t_metric finish_vector();
        t_metric     res;
        logic [63:0] den, mag, q, x, r;
        res = '0;
        if (mode == 1'b0) begin
            if (norm_a_acc == 0 || norm_b_acc == 0) begin
                res.degenerate = 1'b1;
            end else begin
                den = root_floor(norm_a_acc) * root_floor(norm_b_acc);
                mag = (dot_acc < 0) ? -dot_acc : dot_acc;
                q = ((mag << 15) + den / 2) / den;
                if (dot_acc < 0)
                    res.cosine = (q > 32768) ? 16'h8000 : 16'(-q);
                else
                    res.cosine = (q > 32767) ? 16'h7fff : 16'(q);
            end
        end else begin
            x = diff_acc << 2;
            r = root_floor(x);
            if (x - r * r > r) r = r + 1;
            res.distance = (r > 64'd16777215) ? 24'hffffff : 24'(r);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        longint  a, b, d, s;
        t_metric act, exp_res;
        if (!i_rst_n) begin
            mode = 1'b0;
            dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; diff_acc = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) mode = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                a = longint'($signed(i_s_tdata[15:0]));
                b = longint'($signed(i_s_tdata[31:16]));
                d = a - b;
                s = dot_acc + a * b;
                if (s > DOT_LIM) s = DOT_LIM;
                if (s < -DOT_LIM - 1) s = -DOT_LIM - 1;
                dot_acc = s;
                norm_a_acc = (norm_a_acc + a * a > NORM_LIM) ? NORM_LIM : norm_a_acc + a * a;
                norm_b_acc = (norm_b_acc + b * b > NORM_LIM) ? NORM_LIM : norm_b_acc + b * b;
                diff_acc = (diff_acc + d * d > DIFF_LIM) ? DIFF_LIM : diff_acc + d * d;
                if (i_s_tlast) begin
                    expected_q = {expected_q, finish_vector()};
                    dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; diff_acc = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                act.cosine     = i_m_tdata[15:0];
                act.distance   = i_m_tdata[39:16];
                act.degenerate = i_m_tuser;
                o_results_seen = o_results_seen + 1;
                if (expected_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing expected: cos %0d dist %0d degen %0b",
                                 $time, $signed(act.cosine), act.distance, act.degenerate);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (act !== exp_res) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp cos %0d dist %0d degen %0b / got cos %0d dist %0d degen %0b",
                                     $time, $signed(exp_res.cosine), exp_res.distance,
                                     exp_res.degenerate, $signed(act.cosine), act.distance,
                                     act.degenerate);
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results_seen = 0;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for vector_similarity_metric_top
// directed extremes in both metric modes, then random vectors of mostly short
// length with bursty input, a stalling output side and a long output hold-off
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    int  fail_count, pending, results_seen;
    int  cycles = 0;
    int  burst_left = 0;
    int  items_sent = 0;
    int  vectors_cos = 0, vectors_dist = 0;
    bit  hold_request = 0;
    bit  cur_mode = 0;

    always #2 i_clk = ~i_clk;

    vector_similarity_metric_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    vsm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: segments of always-ready, random, mostly-stalled and mostly-ready, plus one long hold-off
    initial begin
        int kind, len;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                repeat (600) @(posedge i_clk) m_tready <= 1'b0;
            end
            kind = $urandom_range(0, 3);
            len  = $urandom_range(10, 150);
            repeat (len) @(posedge i_clk) begin
                case (kind)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit last);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        if (last) begin
            if (cur_mode) vectors_dist++;
            else vectors_cos++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 15);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        cur_mode = m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_vectors(input int n_items);
        int     len, sent, k;
        bit     zero_a, zero_b;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            zero_a = ($urandom_range(0, 15) == 0);
            zero_b = ($urandom_range(0, 15) == 0);
            for (k = 0; k < len; k++)
                send_pair(zero_a ? 16'h0 : pick_elem(), zero_b ? 16'h0 : pick_elem(),
                          k == len - 1);
            sent += len;
        end
    endtask

    initial begin
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cosine extremes, saturation both ways, degenerate norms
        send_pair(16'h8000, 16'h8000, 1);
        send_pair(16'h8000, 16'h7fff, 1);
        send_pair(16'h7fff, 16'h7fff, 1);
        send_pair(16'h0000, 16'h0005, 1);
        send_pair(16'h1234, 16'h0000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0001, 16'hffff, 0);
        send_pair(16'h4000, 16'h4000, 1);
        drain();

        write_mode(1);
        send_pair(16'h7fff, 16'h8000, 1);
        send_pair(16'h8000, 16'h7fff, 0);
        send_pair(16'h7fff, 16'h8000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0001, 16'h0000, 1);
        send_pair(16'h5555, 16'haaaa, 1);
        // mode switch between pairs of one vector: mode at the last pair decides
        send_pair(16'h3000, 16'h1000, 0);
        drain();
        write_mode(0);
        send_pair(16'h2000, 16'hd000, 1);
        send_pair(16'h0100, 16'h0200, 0);
        drain();
        write_mode(1);
        send_pair(16'h0300, 16'hff00, 1);
        drain();

        for (k = 0; k < 4; k++) begin
            write_mode(k[0] ? 1'b1 : 1'b0);
            if (k == 1) hold_request = 1;
            random_vectors(275);
            // sender waits out every outstanding result
            drain();
        end
        write_mode(0);

        $display("sent %0d element pairs: %0d cosine vectors, %0d distance vectors",
                 items_sent, vectors_cos, vectors_dist);
        $display("checked %0d results, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- vector_similarity_metric_top.f -----
rtl/core/vsm_pkg.sv
rtl/core/vsm_mul.sv
rtl/core/vsm_sqrt.sv
rtl/core/vsm_div.sv
rtl/core/vector_similarity_metric_top.sv
tb/vsm_checker.sv
tb/tb.sv
